// ===== rtl/csvfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field parser package
// Shared types and character constants for the CSV field parser core.
// ----------------------------------------------------------------------------
package csvfp_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned CountWidth = 16;

   localparam logic [CharWidth-1:0]  CH_COMMA = 8'h2C;
   localparam logic [CharWidth-1:0]  CH_NL    = 8'h0A;
   localparam logic [CharWidth-1:0]  CH_QUOTE = 8'h22;

   localparam logic [CountWidth-1:0] MAX_LEN_RESET = 16'd256;
   localparam logic [CountWidth-1:0] COUNT_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_OK                = 2'd0,
      ST_END_OF_INPUT      = 2'd1,
      ST_COMMA_EXPECTED    = 2'd2,
      ST_LINE_END_EXPECTED = 2'd3
   } status_type;

   typedef enum logic {
      KIND_CHAR      = 1'b0,
      KIND_FIELD_END = 1'b1
   } kind_type;

endpackage : csvfp_pkg

// ===== rtl/csv_field_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field parser core
// Splits a byte stream into CSV fields with quote handling, a per-field
// length limit and a status beat at each field end.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  req_      in   tdata: in_byte, tuser: is_end, tlast: last_field
//  rsp_      out  tdata: out_char, status; tuser: kind
//  csr_      in   write of max_len
//
//  One beat per cycle sustained while rsp_ is ready. A beat is held in the input
//  register, is parsed there against the field state and lands in the result
//  register. Parse state and field state update when the beat leaves the input
//  register. A stall on rsp_ backs up through both registers; one beat can still
//  be taken while a result waits. Reset clears all control and field state and
//  sets max_len to 256.
module csv_field_parser_core (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] is_end
   input  logic        req_tlast,   // last_field
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_char, [9:8] status, [15:10] zero
   output logic        rsp_tuser    // [0] kind
);

   // configuration
   logic [csvfp_pkg::CountWidth-1:0] max_len_ff;

   // input register
   logic                            stg_valid_ff;
   logic [csvfp_pkg::CharWidth-1:0] stg_byte_ff;
   logic                            stg_end_ff;
   logic                            stg_last_ff;

   // field state
   logic                             in_quotes_ff, in_quotes_in;
   logic                             quote_pending_ff, quote_pending_in;
   logic [csvfp_pkg::CountWidth-1:0] char_count_ff, char_count_in;
   logic                             discarding_ff, discarding_in;

   // result register
   logic                            rsp_valid_ff;
   csvfp_pkg::kind_type             rsp_kind_ff;
   logic [csvfp_pkg::CharWidth-1:0] rsp_char_ff;
   csvfp_pkg::status_type           rsp_status_ff;

   // parse results
   logic                             res_valid;
   csvfp_pkg::kind_type              res_kind;
   logic [csvfp_pkg::CharWidth-1:0]  res_char;
   csvfp_pkg::status_type            res_status;
   logic [csvfp_pkg::CountWidth-1:0] count_inc;
   logic                             quotes_now;
   logic                             is_nl, is_comma, is_quote;

   logic advance;
   logic req_accept;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stg_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign is_nl    = (stg_byte_ff == csvfp_pkg::CH_NL);
   assign is_comma = (stg_byte_ff == csvfp_pkg::CH_COMMA);
   assign is_quote = (stg_byte_ff == csvfp_pkg::CH_QUOTE);
   assign count_inc = (char_count_ff != csvfp_pkg::COUNT_MAX) ?
                      char_count_ff + 1'b1 : char_count_ff;

   always_comb begin
      res_valid        = 1'b0;
      res_kind         = csvfp_pkg::KIND_CHAR;
      res_char         = '0;
      res_status       = csvfp_pkg::ST_OK;
      in_quotes_in     = in_quotes_ff;
      quote_pending_in = quote_pending_ff;
      char_count_in    = char_count_ff;
      discarding_in    = discarding_ff;
      quotes_now       = in_quotes_ff;

      if (discarding_ff) begin
         // drop bytes until the expected delimiter
         if (stg_end_ff || is_nl || (!stg_last_ff && is_comma)) begin
            res_valid        = 1'b1;
            res_kind         = csvfp_pkg::KIND_FIELD_END;
            in_quotes_in     = 1'b0;
            quote_pending_in = 1'b0;
            char_count_in    = '0;
            discarding_in    = 1'b0;
         end
      end else if (quote_pending_ff && !stg_end_ff && is_quote) begin
         // doubled quote: one literal quote, not counted
         quote_pending_in = 1'b0;
         res_valid        = 1'b1;
         res_char         = csvfp_pkg::CH_QUOTE;
      end else begin
         if (quote_pending_ff) begin
            quotes_now       = !in_quotes_ff;
            quote_pending_in = 1'b0;
            in_quotes_in     = quotes_now;
         end
         if (stg_end_ff || is_nl || (is_comma && !quotes_now)) begin
            res_valid = 1'b1;
            res_kind  = csvfp_pkg::KIND_FIELD_END;
            if (char_count_ff == '0 && !stg_last_ff && stg_end_ff)
               res_status = csvfp_pkg::ST_END_OF_INPUT;
            else if (!stg_last_ff && !stg_end_ff && is_comma)
               res_status = csvfp_pkg::ST_OK;
            else if (stg_last_ff && (stg_end_ff || is_nl))
               res_status = csvfp_pkg::ST_OK;
            else if (stg_last_ff)
               res_status = csvfp_pkg::ST_LINE_END_EXPECTED;
            else
               res_status = csvfp_pkg::ST_COMMA_EXPECTED;
            in_quotes_in     = 1'b0;
            quote_pending_in = 1'b0;
            char_count_in    = '0;
            discarding_in    = 1'b0;
         end else begin
            char_count_in = count_inc;
            if (count_inc >= max_len_ff) begin
               discarding_in = 1'b1;
            end else if (is_quote) begin
               quote_pending_in = 1'b1;
            end else begin
               res_valid = 1'b1;
               res_char  = stg_byte_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= csvfp_pkg::MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stg_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_byte_ff <= req_tdata;
         stg_end_ff  <= req_tuser;
         stg_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff     <= 1'b0;
         quote_pending_ff <= 1'b0;
         char_count_ff    <= '0;
         discarding_ff    <= 1'b0;
      end else if (stg_valid_ff && advance) begin
         in_quotes_ff     <= in_quotes_in;
         quote_pending_ff <= quote_pending_in;
         char_count_ff    <= char_count_in;
         discarding_ff    <= discarding_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stg_valid_ff && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stg_valid_ff && res_valid) begin
         rsp_kind_ff   <= res_kind;
         rsp_char_ff   <= res_char;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_char_ff};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_pending_not_discarding : assert property (@(posedge clock) disable iff (reset)
      !(quote_pending_ff && discarding_ff))
      else $error("quote pending while discarding");

   a_field_end_clears : assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && advance && res_valid && res_kind == csvfp_pkg::KIND_FIELD_END)
      |=> (char_count_ff == '0 && !in_quotes_ff && !quote_pending_ff && !discarding_ff))
      else $error("field state not cleared after field end");

   a_char_beat_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == csvfp_pkg::KIND_CHAR)
      |-> rsp_status_ff == csvfp_pkg::ST_OK)
      else $error("character beat with nonzero status");

   a_end_beat_no_char : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == csvfp_pkg::KIND_FIELD_END)
      |-> rsp_char_ff == '0)
      else $error("field end beat carries a character");

endmodule : csv_field_parser_core
